/* src/sidta_pkg.sv */
// Shared types and constants for the signed integer to decimal ASCII converter.
package sidta_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned DigitIdxW  = $clog2(NumDigits);
  localparam int unsigned ShiftCntW  = $clog2(ValueWidth);

  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;

  typedef logic [3:0] bcd_digit_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StLead = 4'b0100,
    StEmit = 4'b1000
  } conv_state_e;

endpackage

/* src/sidta_bcd_cell.sv */
// One decimal digit cell of the shift-add-3 binary to BCD chain.
module sidta_bcd_cell (
  input  logic                  clk_i,
  input  logic                  clear_i,
  input  logic                  shift_i,
  input  logic                  bit_i,
  output logic                  carry_o,
  output sidta_pkg::bcd_digit_t digit_o
);

  sidta_pkg::bcd_digit_t digit_q, digit_d, adjusted;

  assign adjusted = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o  = adjusted[3];
  assign digit_o  = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (clear_i) begin
      digit_d = '0;
    end else if (shift_i) begin
      digit_d = {adjusted[2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

/* src/signed_int_to_decimal_ascii.sv */
// Top level: converts a signed 32-bit integer into a stream of decimal ASCII characters.
//
//   channel   direction   payload             handshake
//   in        input       value_i             in_valid_i / in_stall_o
//   out       output      ascii_code_o, last_o out_valid_o / out_stall_i
//
// A request is taken only while the converter is idle. The magnitude is shifted
// through a row of ten BCD digit cells in the StConv state, the StLead state finds the
// leading digit, and then one character leaves per cycle while the output is not
// stalled. The converter is back in the idle state when the last character is
// presented, and the next request is taken from there. Output stalls hold the
// character register and pause the emission.
// Reset clears the control state only.
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  ascii_code_o,
  output logic        last_o
);

  localparam int unsigned NumDigits = sidta_pkg::NumDigits;
  localparam int unsigned IdxW      = sidta_pkg::DigitIdxW;
  localparam int unsigned CntW      = sidta_pkg::ShiftCntW;

  sidta_pkg::conv_state_e state_q, state_d;
  logic [31:0]            mag_q, mag_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [IdxW-1:0]        idx_q, idx_d, lead;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             ascii_q, ascii_d;
  logic                   last_q, last_d;

  logic                   accept, out_free, clear, shift;
  sidta_pkg::bcd_digit_t  digits [NumDigits];
  logic [NumDigits:0]     carry;

  assign accept   = in_valid_i && (state_q == sidta_pkg::StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign clear    = accept;
  assign shift    = (state_q == sidta_pkg::StConv);
  assign carry[0] = mag_q[31];

  for (genvar k = 0; k < NumDigits; k++) begin : g_cell
    sidta_bcd_cell u_cell (
      .clk_i   (clk_i),
      .clear_i (clear),
      .shift_i (shift),
      .bit_i   (carry[k]),
      .carry_o (carry[k+1]),
      .digit_o (digits[k])
    );
  end

  always_comb begin
    lead = '0;
    for (int k = 0; k < NumDigits; k++) begin
      if (digits[k] != 4'd0) begin
        lead = IdxW'(k);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    ascii_d     = ascii_q;
    last_d      = last_q;
    unique case (state_q)
      sidta_pkg::StIdle: begin
        if (in_valid_i) begin
          neg_d   = value_i[31];
          mag_d   = value_i[31] ? 32'd0 - value_i : value_i;
          cnt_d   = '0;
          state_d = sidta_pkg::StConv;
        end
      end
      sidta_pkg::StConv: begin
        mag_d = {mag_q[30:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = sidta_pkg::StLead;
        end
      end
      sidta_pkg::StLead: begin
        idx_d   = lead;
        state_d = sidta_pkg::StEmit;
      end
      sidta_pkg::StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            ascii_d = sidta_pkg::CharMinus;
            last_d  = 1'b0;
            neg_d   = 1'b0;
          end else begin
            ascii_d = sidta_pkg::CharZero + {4'd0, digits[idx_q]};
            last_d  = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = sidta_pkg::StIdle;
            end else begin
              idx_d = idx_q - 1'b1;
            end
          end
        end
      end
      default: state_d = sidta_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sidta_pkg::StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    ascii_q <= ascii_d;
    last_q  <= last_d;
  end

  assign in_stall_o   = (state_q != sidta_pkg::StIdle);
  assign out_valid_o  = out_valid_q;
  assign ascii_code_o = ascii_q;
  assign last_o       = last_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the signed integer to decimal ASCII converter.
module testbench;

  localparam int unsigned RandomItems = 160;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned NumRows     = 20;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_t;

  typedef struct {
    logic [31:0] value;
    string       text;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  ascii_code_o;
  logic        last_o;

  char_t pending_chars[$];
  int    errors;
  int    numbers_sent;
  int    negatives_sent;
  int    chars_checked;
  int    cycle_cnt;
  bit    quiet;

  // An empty text means the row is checked against the predictor.
  row_t dir_rows [0:NumRows-1] = '{
    '{32'd0,           "0"},
    '{32'd1,           ""},
    '{-32'sd1,         "-1"},
    '{32'd9,           ""},
    '{32'd10,          ""},
    '{-32'sd10,        ""},
    '{32'd99,          ""},
    '{32'd100,         ""},
    '{-32'sd9,         ""},
    '{32'd1234567890,  ""},
    '{32'd999999999,   ""},
    '{32'd1000000000,  ""},
    '{-32'sd999999999, ""},
    '{32'h7fffffff,    "2147483647"},
    '{32'h80000001,    ""},
    '{32'h80000000,    "-2147483648"},
    '{32'h55555555,    ""},
    '{32'haaaaaaaa,    ""},
    '{32'h0000ffff,    ""},
    '{32'hffff0000,    ""}
  };

  signed_int_to_decimal_ascii u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_code_o (ascii_code_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void queue_predicted(logic [31:0] v);
    logic [31:0] mag;
    logic [3:0]  digs [10];
    int          n;
    mag = v[31] ? (~v + 32'd1) : v;
    n = 0;
    do begin
      digs[n] = 4'(mag % 32'd10);
      n++;
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    if (v[31]) pending_chars.push_back(char_t'{sidta_pkg::CharMinus, 1'b0});
    for (int k = n - 1; k >= 0; k--) begin
      pending_chars.push_back(char_t'{sidta_pkg::CharZero + 8'(digs[k]), k == 0});
    end
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back(char_t'{8'(s[i]), i == s.len() - 1});
    end
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  task automatic send_value(logic [31:0] v, string text);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    if (text.len() == 0) queue_predicted(v);
    else queue_text(text);
    numbers_sent++;
    if (v[31]) negatives_sent++;
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    logic [31:0] p;
    int          k;
    case ($urandom_range(0, 4))
      0: v = $urandom();
      1: v = $urandom_range(0, 999);
      2: begin
        p = 32'd1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 32'd10;
        v = p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      3: v = $urandom_range(0, 1) ? 32'h7fffffff - 32'($urandom_range(0, 20))
                                  : 32'h80000000 + 32'($urandom_range(0, 20));
      default: v = $urandom_range(0, 99999);
    endcase
    if (v[31] == 1'b0 && $urandom_range(0, 1)) v = ~v + 32'd1;
    return v;
  endfunction

  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      int hold;
      hold = quiet ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last %b", ascii_code_o, last_o));
      end else begin
        want = pending_chars.pop_front();
        if (ascii_code_o !== want.code)
          report_mismatch($sformatf("character 0x%02h, wanted 0x%02h", ascii_code_o, want.code));
        if (last_o !== want.last)
          report_mismatch($sformatf("last flag %b, wanted %b", last_o, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timed out with %0d characters outstanding.", pending_chars.size());
      $display("signed_int_to_decimal_ascii regression: fail");
      $finish;
    end
  end

  initial begin
    errors         = 0;
    numbers_sent   = 0;
    negatives_sent = 0;
    chars_checked  = 0;
    quiet          = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    value_i    <= 32'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) send_value(dir_rows[i].value, dir_rows[i].text);

    // The last 15 of every 60 items run without any idling on either side.
    for (int i = 0; i < RandomItems; i++) begin
      quiet = (i % 60) >= 45;
      send_value(random_value(), "");
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Converted %0d numbers, %0d of them negative, and checked %0d characters.",
             numbers_sent, negatives_sent, chars_checked);
    $display("Mismatches found: %0d.", errors);
    if (errors == 0) begin
      $display("signed_int_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_int_to_decimal_ascii regression: fail");
    end
    $finish;
  end

endmodule
